// ===== src/dlstq_pkg.sv =====
// ----------------------------------------------------------------------------
// dlstq_pkg
// Shared types and constants for the delta list sleep timer queue.
// ----------------------------------------------------------------------------
package dlstq_pkg;

   localparam int DefaultMaxSleepers = 16;
   localparam int ResultCap          = 16;
   localparam logic [2:0] ResolutionReset = 3'd3;

   typedef enum logic [2:0] {
      STATUS_NONE     = 3'd0,
      STATUS_RELEASED = 3'd1,
      STATUS_INSERTED = 3'd2,
      STATUS_IGNORED  = 3'd3,
      STATUS_FULL     = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TICK,
      ST_RELEASE,
      ST_WALK,
      ST_SHIFT,
      ST_OUT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic       load;       // capture input word
      logic       tick_inc;   // bump counter on a tick word
      logic       head_sub;   // reduce head delta by step
      logic       pop;        // shift list down one
      logic       walk_step;  // compare/subtract one entry
      logic       shift_step; // move one entry up
      logic       insert;     // write new entry, count up
      logic       set_out;    // write result register
      status_type out_status;
      logic       out_rel;    // result carries head id
      logic       out_last;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic action;
      logic nonpos;
      logic full;
      logic empty;
      logic update;     // counter hit resolution boundary
      logic head_due;   // head delta <= 0
      logic next_due;   // second entry delta <= 0
      logic walk_done;  // position found
      logic shift_done;
      logic one_left;   // only one entry remains
      logic cap_hit;    // release cap reached after this one
   } sts_type;

endpackage

// ===== src/dlstq_datapath.sv =====
// ----------------------------------------------------------------------------
// dlstq_datapath
// Tick counter, delta list storage, insert walk and result register.
// ----------------------------------------------------------------------------
module dlstq_datapath import dlstq_pkg::*; #(
   parameter int MaxSleepers = DefaultMaxSleepers
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [2:0]  res_log2,
   input  logic        req_action,
   input  logic [3:0]  req_sleeper_id,
   input  logic [31:0] req_sleep_count,
   input  cmd_type     cmd,
   output sts_type     sts,
   output logic [2:0]  out_status,
   output logic [3:0]  out_id,
   output logic [31:0] out_tick,
   output logic        out_last
);
   localparam int IdxW = $clog2(MaxSleepers);
   localparam int CntW = $clog2(MaxSleepers + 1);
   localparam int RelW = $clog2(ResultCap + 1);

   logic [31:0]     tick_ff, tick_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [31:0]     delta_ff [MaxSleepers];
   logic [3:0]      id_ff    [MaxSleepers];
   logic            action_ff;
   logic [3:0]      sid_ff;
   logic [31:0]     rem_ff, rem_in;
   logic [CntW-1:0] pos_ff, pos_in;
   logic [CntW-1:0] ptr_ff, ptr_in;
   logic [RelW-1:0] rel_ff, rel_in;
   logic [2:0]      ost_ff;
   logic [3:0]      oid_ff;
   logic [31:0]     otick_ff;
   logic            olast_ff;

   logic [31:0] step;
   logic [31:0] pos_delta;
   logic        pos_valid;

   assign step      = 32'd1 << res_log2;
   assign pos_valid = pos_ff < count_ff;
   assign pos_delta = delta_ff[pos_ff[IdxW-1:0]];

   always_comb begin
      tick_in  = tick_ff;
      count_in = count_ff;
      rem_in   = rem_ff;
      pos_in   = pos_ff;
      ptr_in   = ptr_ff;
      rel_in   = rel_ff;
      if (cmd.load) begin
         rem_in = req_sleep_count;
         pos_in = '0;
         rel_in = '0;
      end
      if (cmd.tick_inc && !req_action) tick_in = tick_ff + 32'd1;
      if (cmd.pop) begin
         count_in = count_ff - 1'b1;
         rel_in   = rel_ff + 1'b1;
      end
      if (cmd.walk_step) begin
         if (pos_valid && $signed(pos_delta) < $signed(rem_ff)) begin
            rem_in = rem_ff - pos_delta;
            pos_in = pos_ff + 1'b1;
         end else begin
            ptr_in = count_ff;
         end
      end
      if (cmd.shift_step) ptr_in = ptr_ff - 1'b1;
      if (cmd.insert) count_in = count_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff  <= '0;
         count_ff <= '0;
      end else begin
         tick_ff  <= tick_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      pos_ff <= pos_in;
      ptr_ff <= ptr_in;
      rel_ff <= rel_in;
      if (cmd.load) begin
         action_ff <= req_action;
         sid_ff    <= req_sleeper_id;
      end
      if (cmd.head_sub) delta_ff[0] <= delta_ff[0] - step;
      if (cmd.pop) begin
         for (int i = 1; i < MaxSleepers; i++) begin
            delta_ff[i-1] <= delta_ff[i];
            id_ff[i-1]    <= id_ff[i];
         end
      end
      if (cmd.walk_step && !(pos_valid && $signed(pos_delta) < $signed(rem_ff))
          && pos_valid)
         delta_ff[pos_ff[IdxW-1:0]] <= pos_delta - rem_ff;
      if (cmd.shift_step) begin
         delta_ff[ptr_ff[IdxW-1:0]] <= delta_ff[ptr_ff[IdxW-1:0] - 1'b1];
         id_ff[ptr_ff[IdxW-1:0]]    <= id_ff[ptr_ff[IdxW-1:0] - 1'b1];
      end
      if (cmd.insert) begin
         delta_ff[pos_ff[IdxW-1:0]] <= rem_ff;
         id_ff[pos_ff[IdxW-1:0]]    <= sid_ff;
      end
      if (cmd.set_out) begin
         ost_ff   <= cmd.out_status;
         oid_ff   <= cmd.out_rel ? id_ff[0] : 4'd0;
         otick_ff <= tick_ff;
         olast_ff <= cmd.out_last;
      end
   end

   assign sts.action     = action_ff;
   assign sts.nonpos     = $signed(rem_ff) <= 0;
   assign sts.full       = count_ff >= CntW'(MaxSleepers);
   assign sts.empty      = count_ff == '0;
   assign sts.update     = (tick_ff & (step - 32'd1)) == '0;
   assign sts.head_due   = $signed(delta_ff[0]) <= 0;
   assign sts.next_due   = $signed(delta_ff[1]) <= 0;
   assign sts.walk_done  = !(pos_valid && $signed(pos_delta) < $signed(rem_ff));
   assign sts.shift_done = ptr_ff == pos_ff;
   assign sts.one_left   = count_ff == CntW'(1);
   assign sts.cap_hit    = rel_ff == RelW'(ResultCap - 1);

   assign out_status = ost_ff;
   assign out_id     = oid_ff;
   assign out_tick   = otick_ff;
   assign out_last   = olast_ff;
endmodule

// ===== src/dlstq_ctrl.sv =====
// ----------------------------------------------------------------------------
// dlstq_ctrl
// Sequencer for tick release and sorted insert.
// ----------------------------------------------------------------------------
module dlstq_ctrl import dlstq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   input  sts_type sts,
   output cmd_type cmd
);
   state_type state_ff, state_in;
   logic      ovalid_ff, ovalid_in;
   logic      oslot;
   logic      rel_last;

   assign oslot     = !ovalid_ff || !rsp_stall;
   assign rsp_valid = ovalid_ff;
   assign req_stall = state_ff != ST_IDLE;
   // last release: list runs dry, cap reached or next head not yet due
   assign rel_last  = sts.one_left || sts.cap_hit || !sts.next_due;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:    if (req_valid) state_in = ST_TICK;
         ST_TICK: begin
            if (!sts.action) begin
               if (sts.update && !sts.empty) state_in = ST_RELEASE;
               else if (oslot) state_in = ST_IDLE;
            end else if (sts.nonpos || sts.full) begin
               if (oslot) state_in = ST_IDLE;
            end else begin
               state_in = ST_WALK;
            end
         end
         ST_RELEASE: begin
            if (oslot) begin
               if (!sts.head_due) state_in = ST_OUT;
               else if (rel_last) state_in = ST_IDLE;
            end
         end
         ST_WALK:    if (sts.walk_done) state_in = ST_SHIFT;
         ST_SHIFT:   if (sts.shift_done && oslot) state_in = ST_IDLE;
         ST_OUT:     if (oslot) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.out_status = STATUS_NONE;
      ovalid_in = ovalid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load     = 1'b1;
               cmd.tick_inc = 1'b1;
            end
         end
         ST_TICK: begin
            if (!sts.action) begin
               if (sts.update && !sts.empty) begin
                  cmd.head_sub = 1'b1;
               end else if (oslot) begin
                  cmd.set_out = 1'b1;
                  cmd.out_last = 1'b1;
                  ovalid_in = 1'b1;
               end
            end else if (sts.nonpos || sts.full) begin
               if (oslot) begin
                  cmd.set_out = 1'b1;
                  cmd.out_last = 1'b1;
                  cmd.out_status = sts.nonpos ? STATUS_IGNORED : STATUS_FULL;
                  ovalid_in = 1'b1;
               end
            end
         end
         ST_RELEASE: begin
            if (oslot) begin
               if (sts.head_due) begin
                  cmd.set_out = 1'b1;
                  cmd.out_rel = 1'b1;
                  cmd.out_status = STATUS_RELEASED;
                  cmd.out_last = rel_last;
                  cmd.pop = 1'b1;
                  ovalid_in = 1'b1;
               end
            end
         end
         ST_WALK: cmd.walk_step = 1'b1;
         ST_SHIFT: begin
            if (!sts.shift_done) cmd.shift_step = 1'b1;
            else if (oslot) begin
               cmd.insert = 1'b1;
               cmd.set_out = 1'b1;
               cmd.out_last = 1'b1;
               cmd.out_status = STATUS_INSERTED;
               ovalid_in = 1'b1;
            end
         end
         ST_OUT: begin
            // update released nothing: close with a none word
            if (oslot) begin
               cmd.set_out = 1'b1;
               cmd.out_last = 1'b1;
               ovalid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ovalid_ff <= ovalid_in;
      end
   end
endmodule

// ===== src/delta_list_sleep_timer_queue_top.sv =====
// ----------------------------------------------------------------------------
// Delta list sleep timer queue
// One word is in work at a time; results wait in an output register. A tick
// word goes from ST_TICK back to idle, or on an update to ST_RELEASE, which
// gives one result word per released sleeper, and to ST_OUT for a none word
// when the update releases nothing. An insert word walks and then shifts the
// sorted list one entry per cycle; ignored and rejected inserts are answered
// from ST_TICK. Every result word waits while the result register is stalled.
// ----------------------------------------------------------------------------
module delta_list_sleep_timer_queue_top import dlstq_pkg::*; #(
   parameter int MaxSleepers = DefaultMaxSleepers
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_resolution_log2,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [3:0]  req_sleeper_id,
   input  logic [31:0] req_sleep_count,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [3:0]  rsp_released_id,
   output logic [31:0] rsp_tick_count,
   output logic        rsp_last
);
   logic [2:0] res_ff;
   cmd_type    cmd;
   sts_type    sts;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) res_ff <= ResolutionReset;
      else if (csr_valid) res_ff <= csr_resolution_log2;
   end

   dlstq_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .sts, .cmd
   );

   dlstq_datapath #(.MaxSleepers(MaxSleepers)) u_dp (
      .clock, .reset, .res_log2(res_ff), .req_action, .req_sleeper_id,
      .req_sleep_count, .cmd, .sts,
      .out_status(rsp_status), .out_id(rsp_released_id),
      .out_tick(rsp_tick_count), .out_last(rsp_last)
   );
endmodule

// ===== src/dlstq_checker.sv =====
// ----------------------------------------------------------------------------
// dlstq_checker
// Port-level checks on the timer queue.
// ----------------------------------------------------------------------------
module dlstq_checker import dlstq_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_status,
   input logic [3:0]  rsp_released_id,
   input logic [31:0] rsp_tick_count,
   input logic        rsp_last
);
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("accepted twice in a row");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_tick_count))
      else $error("held word changed");
   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= STATUS_FULL)
      else $error("bad status");
   a_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_RELEASED |-> rsp_released_id == 4'd0)
      else $error("id without release");
   a_lastone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_RELEASED |-> rsp_last)
      else $error("single word without last");
endmodule

bind delta_list_sleep_timer_queue_top dlstq_checker u_chk (
   .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
   .rsp_status, .rsp_released_id, .rsp_tick_count, .rsp_last
);
